>>> hdl/fpp_pkg.sv
// ----------------------------------------------------------------------------
// fpp_pkg
// Shared widths, constants, register codes and helpers for the page
// placement pipeline.
// ----------------------------------------------------------------------------
package fpp_pkg;

  localparam int SCALE_FRAC_BITS_DEF = 16;

  localparam int PAGEW = 24;   // page size in points, 16.8
  localparam int DIMW  = 16;   // printable size in pixels
  localparam int DPIW  = 14;
  localparam int NATW  = 38;   // natural size numerator over PT_DEN
  localparam int PRODW = 54;   // printable size times natural size
  localparam int DENW  = 40;   // divisor width in the divider row
  localparam int QW    = 25;   // quotient bits, one per cell
  localparam int RESW  = 24;
  localparam int CROPW = 17;
  localparam int YW    = 28;   // (2n + PT_DEN) / 4096, fed to the divide by 9

  localparam logic [14:0]     PT_DEN = 15'd18432;      // 256 * 72
  localparam logic [YW-1:0]   RECIP9 = 28'd238609294;  // floor(2^31 / 9)
  localparam logic [RESW-1:0] MAX24  = 24'hFFFFFF;

  localparam logic [1:0] ORIENT_PORTRAIT  = 2'd0;
  localparam logic [1:0] ORIENT_LANDSCAPE = 2'd1;
  localparam logic [1:0] ORIENT_AUTO      = 2'd2;
  localparam logic       MODE_FIT         = 1'b0;

  typedef enum logic [2:0] {
    REG_PRINT_W = 3'd0,
    REG_PRINT_H = 3'd1,
    REG_DPI_X   = 3'd2,
    REG_DPI_Y   = 3'd3,
    REG_MODE    = 3'd4,
    REG_ORIENT  = 3'd5
  } cfg_reg_t;

  // Per-item flags and precomputed actual-size dimensions that ride along
  // with the divider lanes.
  typedef struct packed {
    logic            invalid;
    logic            land;
    logic            wlim;     // width is the limiting axis in fit mode
    logic            ovf;      // scale quotient exceeds the quotient range
    logic [RESW-1:0] dwa;
    logic [RESW-1:0] dha;
  } fpp_side_t;

  // Saturate a quotient to 24 bits and force a minimum of one.
  function automatic logic [RESW-1:0] clamp_dim(input logic [QW-1:0] v);
    logic [RESW-1:0] r;
    if (v == '0) begin
      r = 24'd1;
    end else if (v[QW-1]) begin
      r = MAX24;
    end else begin
      r = v[RESW-1:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/fpp_prep.sv
// ----------------------------------------------------------------------------
// fpp_prep
// Three front stages: natural size and orientation, cross products, and
// divider operand setup for both lanes.
// ----------------------------------------------------------------------------
module fpp_prep
  import fpp_pkg::*;
#(
  parameter int SFB = SCALE_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [2:0]                 adv,
  input  logic                       vld_i,
  input  logic [PAGEW-1:0]           page_w,
  input  logic [PAGEW-1:0]           page_h,
  input  logic [DIMW-1:0]            aw,
  input  logic [DIMW-1:0]            ah,
  input  logic [DPIW-1:0]            dpix,
  input  logic [DPIW-1:0]            dpiy,
  input  logic                       mode,
  input  logic [1:0]                 orient,
  output logic [2:0]                 vld_o,
  output logic [1:0][DENW-1:0]       rem_o,
  output logic [1:0][QW-1:0]         low_o,
  output logic [1:0][DENW-1:0]       den_o,
  output fpp_side_t                  side_o
);

  localparam int NUMW = (SFB + 33 > 62) ? SFB + 33 : 62;
  localparam int CMPW = (NUMW - QW > DENW) ? NUMW - QW : DENW;

  logic [2:0] vld_r;

  // stage 1
  logic            s1_inv_r, s1_land_r;
  logic [NATW-1:0] s1_nw_r, s1_nh_r;
  logic            inv_nxt, land_nxt, swap;
  logic [NATW-1:0] nw_raw, nh_raw;

  // stage 2
  logic             s2_inv_r, s2_land_r;
  logic [NATW-1:0]  s2_nw_r, s2_nh_r;
  logic [PRODW-1:0] s2_pa_r, s2_pb_r;
  logic [YW-1:0]    s2_yw_r, s2_yh_r;
  logic [2*YW-1:0]  s2_mw_r, s2_mh_r;
  logic [NATW+1:0]  tw, th;

  // stage 3
  logic [1:0][DENW-1:0] rem_r, den_r;
  logic [1:0][QW-1:0]   low_r;
  fpp_side_t            side_r;

  logic             wl;
  logic [DIMW-1:0]  a_sel;
  logic [NATW-1:0]  nd_sel, vw, vh, awp, ahp;
  logic [PRODW-1:0] p_sel;
  logic [NUMW-1:0]  sn, dn, an0, an1;
  logic [DENW-1:0]  sd, ad0, ad1;
  logic             ovf;
  logic [QW-1:0]    qw0, qh0, qw, qh;
  logic [YW-1:0]    rw, rh;
  logic [1:0][NUMW-1:0] num;
  logic [1:0][DENW-1:0] den_nxt;

  always_comb begin
    inv_nxt = (page_w == '0) || (page_h == '0) || (aw == '0) || (ah == '0) ||
              (dpix == '0) || (dpiy == '0);
    case (orient)
      ORIENT_PORTRAIT:  land_nxt = 1'b0;
      ORIENT_LANDSCAPE: land_nxt = 1'b1;
      default:          land_nxt = page_w > page_h;
    endcase
    nw_raw = NATW'(page_w) * NATW'(dpix);
    nh_raw = NATW'(page_h) * NATW'(dpiy);
    swap   = (aw > ah) != land_nxt;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_inv_r  <= inv_nxt;
      s1_land_r <= land_nxt;
      s1_nw_r   <= swap ? nh_raw : nw_raw;
      s1_nh_r   <= swap ? nw_raw : nh_raw;
    end
  end

  // Round half up of n / 18432 is floor((2n + 18432) / 4096 / 9).
  always_comb begin
    tw = {1'b0, s1_nw_r, 1'b0} + (NATW+2)'(PT_DEN);
    th = {1'b0, s1_nh_r, 1'b0} + (NATW+2)'(PT_DEN);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_inv_r  <= s1_inv_r;
      s2_land_r <= s1_land_r;
      s2_nw_r   <= s1_nw_r;
      s2_nh_r   <= s1_nh_r;
      s2_pa_r   <= PRODW'(aw) * PRODW'(s1_nh_r);
      s2_pb_r   <= PRODW'(ah) * PRODW'(s1_nw_r);
      s2_yw_r   <= tw[NATW+1:12];
      s2_yh_r   <= th[NATW+1:12];
      s2_mw_r   <= (2*YW)'(tw[NATW+1:12]) * (2*YW)'(RECIP9);
      s2_mh_r   <= (2*YW)'(th[NATW+1:12]) * (2*YW)'(RECIP9);
    end
  end

  always_comb begin
    wl     = s2_pa_r <= s2_pb_r;
    a_sel  = wl ? aw : ah;
    nd_sel = wl ? s2_nw_r : s2_nh_r;
    p_sel  = wl ? s2_pa_r : s2_pb_r;
    sn  = ((NUMW'(a_sel) * NUMW'(PT_DEN)) << (SFB + 1)) + NUMW'(nd_sel);
    sd  = DENW'({nd_sel, 1'b0});
    dn  = (NUMW'(p_sel) << 1) + NUMW'(nd_sel);
    ovf = CMPW'(sn >> QW) >= CMPW'(sd);

    awp = NATW'(aw) * NATW'(PT_DEN);
    ahp = NATW'(ah) * NATW'(PT_DEN);
    vw  = (s2_nw_r < awp) ? s2_nw_r : awp;
    vh  = (s2_nh_r < ahp) ? s2_nh_r : ahp;
    an0 = NUMW'(vw) << 24;
    an1 = NUMW'(vh) << 24;
    ad0 = DENW'(s2_nw_r);
    ad1 = DENW'(s2_nh_r);

    // The reciprocal estimate is low by at most one.
    qw0 = s2_mw_r[2*YW-1:31];
    qh0 = s2_mh_r[2*YW-1:31];
    rw  = s2_yw_r - YW'({qw0, 3'b000}) - YW'(qw0);
    rh  = s2_yh_r - YW'({qh0, 3'b000}) - YW'(qh0);
    qw  = (rw >= YW'(9)) ? qw0 + QW'(1) : qw0;
    qh  = (rh >= YW'(9)) ? qh0 + QW'(1) : qh0;

    if (mode == MODE_FIT) begin
      num[0]     = sn;
      den_nxt[0] = sd;
      num[1]     = dn;
      den_nxt[1] = sd;
    end else begin
      num[0]     = an0;
      den_nxt[0] = ad0;
      num[1]     = an1;
      den_nxt[1] = ad1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int l = 0; l < 2; l++) begin
        rem_r[l] <= DENW'(num[l] >> QW);
        low_r[l] <= num[l][QW-1:0];
        den_r[l] <= den_nxt[l];
      end
      side_r.invalid <= s2_inv_r;
      side_r.land    <= s2_land_r;
      side_r.wlim    <= wl;
      side_r.ovf     <= (mode == MODE_FIT) && ovf;
      side_r.dwa     <= clamp_dim(qw);
      side_r.dha     <= clamp_dim(qh);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= vld_i;
      if (adv[1]) vld_r[1] <= vld_r[0];
      if (adv[2]) vld_r[2] <= vld_r[1];
    end
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign low_o  = low_r;
  assign den_o  = den_r;
  assign side_o = side_r;

endmodule

>>> hdl/fpp_cell.sv
// ----------------------------------------------------------------------------
// fpp_cell
// One cell of the divider row: a restoring step on each of two lanes,
// producing one quotient bit per lane.
// ----------------------------------------------------------------------------
module fpp_cell
  import fpp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 vld_i,
  input  logic [1:0][DENW-1:0] rem_i,
  input  logic [1:0][QW-1:0]   low_i,
  input  logic [1:0][QW-1:0]   quo_i,
  input  logic [1:0][DENW-1:0] den_i,
  input  fpp_side_t            side_i,
  output logic                 vld_o,
  output logic [1:0][DENW-1:0] rem_o,
  output logic [1:0][QW-1:0]   low_o,
  output logic [1:0][QW-1:0]   quo_o,
  output logic [1:0][DENW-1:0] den_o,
  output fpp_side_t            side_o
);

  logic                 vld_r;
  logic [1:0][DENW-1:0] rem_r, den_r;
  logic [1:0][QW-1:0]   low_r, quo_r;
  fpp_side_t            side_r;

  logic [1:0][DENW:0]   trial, diff;
  logic [1:0]           ge;
  logic [1:0][DENW-1:0] rem_nxt;
  logic [1:0][QW-1:0]   low_nxt, quo_nxt;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      trial[l]   = {rem_i[l], low_i[l][QW-1]};
      diff[l]    = trial[l] - {1'b0, den_i[l]};
      ge[l]      = trial[l] >= {1'b0, den_i[l]};
      rem_nxt[l] = ge[l] ? diff[l][DENW-1:0] : trial[l][DENW-1:0];
      low_nxt[l] = {low_i[l][QW-2:0], 1'b0};
      quo_nxt[l] = {quo_i[l][QW-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r  <= rem_nxt;
      low_r  <= low_nxt;
      quo_r  <= quo_nxt;
      den_r  <= den_i;
      side_r <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign low_o  = low_r;
  assign quo_o  = quo_r;
  assign den_o  = den_r;
  assign side_o = side_r;

endmodule

>>> hdl/fpp_finish.sv
// ----------------------------------------------------------------------------
// fpp_finish
// Result stage: picks dimensions, saturates, centers, computes the crop
// fraction and holds the result item.
// ----------------------------------------------------------------------------
module fpp_finish
  import fpp_pkg::*;
#(
  parameter int SFB = SCALE_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      vld_i,
  input  logic [1:0][QW-1:0]        quo_i,
  input  fpp_side_t                 side_i,
  input  logic [DIMW-1:0]           aw,
  input  logic [DIMW-1:0]           ah,
  input  logic                      mode,
  output logic                      vld_o,
  output logic                      valid_res,
  output logic                      landscape,
  output logic [RESW-1:0]           scale_factor,
  output logic [RESW-1:0]           dest_width,
  output logic [RESW-1:0]           dest_height,
  output logic signed [RESW-1:0]    dest_x,
  output logic signed [RESW-1:0]    dest_y,
  output logic                      will_crop,
  output logic [CROPW-1:0]          crop_fraction
);

  localparam logic [RESW:0]   ONE_FULL = 25'd1 << SFB;
  localparam logic [RESW-1:0] ONE_SAT  = ONE_FULL[RESW] ? MAX24 : ONE_FULL[RESW-1:0];

  logic                   vld_r;
  logic                   valid_res_r, landscape_r, will_crop_r;
  logic [RESW-1:0]        scale_r, dw_r, dh_r, dx_r, dy_r;
  logic [CROPW-1:0]       crop_r;

  logic [RESW-1:0]  scale, dw, dh;
  logic             crops;
  logic [2*QW-1:0]  keep_prod;
  logic [17:0]      keep;
  logic [CROPW-1:0] crop;
  logic [RESW:0]    xdiff, ydiff, xsum, ysum;

  always_comb begin
    if (mode == MODE_FIT) begin
      scale = side_i.ovf ? MAX24 :
              (quo_i[0][QW-1] ? MAX24 : quo_i[0][RESW-1:0]);
      if (side_i.wlim) begin
        dw = RESW'(aw);
        dh = clamp_dim(quo_i[1]);
      end else begin
        dw = clamp_dim(quo_i[1]);
        dh = RESW'(ah);
      end
    end else begin
      scale = ONE_SAT;
      dw    = side_i.dwa;
      dh    = side_i.dha;
    end
    crops = (mode != MODE_FIT) && ((dw > RESW'(aw)) || (dh > RESW'(ah)));

    keep_prod = ((2*QW)'(quo_i[0]) * (2*QW)'(quo_i[1])) + (2*QW)'(64'h8000_0000);
    keep      = keep_prod[2*QW-1:32];
    crop      = (keep >= 18'd65536) ? '0 : CROPW'(18'd65536 - keep);

    // Halving toward zero: add one to negative values before the shift.
    xdiff = (RESW+1)'(aw) - {1'b0, dw};
    ydiff = (RESW+1)'(ah) - {1'b0, dh};
    xsum  = xdiff + (RESW+1)'(xdiff[RESW]);
    ysum  = ydiff + (RESW+1)'(ydiff[RESW]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (side_i.invalid) begin
        valid_res_r <= 1'b0;
        landscape_r <= 1'b0;
        scale_r     <= '0;
        dw_r        <= '0;
        dh_r        <= '0;
        dx_r        <= '0;
        dy_r        <= '0;
        will_crop_r <= 1'b0;
        crop_r      <= '0;
      end else begin
        valid_res_r <= 1'b1;
        landscape_r <= side_i.land;
        scale_r     <= scale;
        dw_r        <= dw;
        dh_r        <= dh;
        dx_r        <= xsum[RESW:1];
        dy_r        <= ysum[RESW:1];
        will_crop_r <= crops;
        crop_r      <= crops ? crop : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  assign vld_o         = vld_r;
  assign valid_res     = valid_res_r;
  assign landscape     = landscape_r;
  assign scale_factor  = scale_r;
  assign dest_width    = dw_r;
  assign dest_height   = dh_r;
  assign dest_x        = dx_r;
  assign dest_y        = dy_r;
  assign will_crop     = will_crop_r;
  assign crop_fraction = crop_r;

endmodule

>>> hdl/fit_page_placement.sv
// ----------------------------------------------------------------------------
// fit_page_placement
// Places a page on the printable area: fit or actual size, centered.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (page width and height in 16.8 points) arrive on in_valid /
//   in_stall; result items leave on out_valid / out_stall. An item moves at
//   an edge where valid is high and stall is low.
//   Registers are written through cfg_wr_en / cfg_index / cfg_wdata and must
//   only change while no item is in flight.
//   The result of an item shows on out_valid after it passes three setup
//   stages, a row of 25 divider cells that each resolve one quotient bit on
//   two lanes, and the result register, 29 registers in all. One item is
//   accepted per cycle while in_stall is low.
//   Every stage holds its item when the stage after it is full and stalled,
//   so in_stall only rises once all stages hold items and out_stall is high;
//   empty stages keep filling while the result waits.
//   Synchronous reset empties the pipeline and loads the default printable
//   area (4960 x 7016 at 600 dpi), fit mode and automatic orientation.
// ----------------------------------------------------------------------------
module fit_page_placement
  import fpp_pkg::*;
#(
  parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [PAGEW-1:0]        in_page_width,
  input  logic [PAGEW-1:0]        in_page_height,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_valid_res,
  output logic                    out_landscape,
  output logic [RESW-1:0]         out_scale_factor,
  output logic [RESW-1:0]         out_dest_width,
  output logic [RESW-1:0]         out_dest_height,
  output logic signed [RESW-1:0]  out_dest_x,
  output logic signed [RESW-1:0]  out_dest_y,
  output logic                    out_will_crop,
  output logic [CROPW-1:0]        out_crop_fraction,
  input  logic                    cfg_wr_en,
  input  logic [2:0]              cfg_index,
  input  logic [DIMW-1:0]         cfg_wdata
);

  localparam int NS = 3 + QW + 1;

  logic [DIMW-1:0] aw_r, ah_r;
  logic [DPIW-1:0] dpix_r, dpiy_r;
  logic            mode_r;
  logic [1:0]      orient_r;

  logic [NS-1:0] stg_vld, en;

  logic [1:0][DENW-1:0] ch_rem [QW+1];
  logic [1:0][QW-1:0]   ch_low [QW+1];
  logic [1:0][QW-1:0]   ch_quo [QW+1];
  logic [1:0][DENW-1:0] ch_den [QW+1];
  fpp_side_t            ch_side[QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_r     <= 16'd4960;
      ah_r     <= 16'd7016;
      dpix_r   <= 14'd600;
      dpiy_r   <= 14'd600;
      mode_r   <= MODE_FIT;
      orient_r <= ORIENT_AUTO;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_PRINT_W: aw_r     <= cfg_wdata;
        REG_PRINT_H: ah_r     <= cfg_wdata;
        REG_DPI_X:   dpix_r   <= cfg_wdata[DPIW-1:0];
        REG_DPI_Y:   dpiy_r   <= cfg_wdata[DPIW-1:0];
        REG_MODE:    mode_r   <= cfg_wdata[0];
        REG_ORIENT:  orient_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its item moves on this cycle.
  always_comb begin
    en[NS-1] = !stg_vld[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !stg_vld[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  fpp_prep #(.SFB(SCALE_FRAC_BITS)) u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (en[2:0]),
    .vld_i  (in_valid),
    .page_w (in_page_width),
    .page_h (in_page_height),
    .aw     (aw_r),
    .ah     (ah_r),
    .dpix   (dpix_r),
    .dpiy   (dpiy_r),
    .mode   (mode_r),
    .orient (orient_r),
    .vld_o  (stg_vld[2:0]),
    .rem_o  (ch_rem[0]),
    .low_o  (ch_low[0]),
    .den_o  (ch_den[0]),
    .side_o (ch_side[0])
  );

  assign ch_quo[0] = '0;

  for (genvar c = 0; c < QW; c++) begin : g_cell
    fpp_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (en[3+c]),
      .vld_i  (stg_vld[2+c]),
      .rem_i  (ch_rem[c]),
      .low_i  (ch_low[c]),
      .quo_i  (ch_quo[c]),
      .den_i  (ch_den[c]),
      .side_i (ch_side[c]),
      .vld_o  (stg_vld[3+c]),
      .rem_o  (ch_rem[c+1]),
      .low_o  (ch_low[c+1]),
      .quo_o  (ch_quo[c+1]),
      .den_o  (ch_den[c+1]),
      .side_o (ch_side[c+1])
    );
  end

  fpp_finish #(.SFB(SCALE_FRAC_BITS)) u_finish (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (en[NS-1]),
    .vld_i         (stg_vld[NS-2]),
    .quo_i         (ch_quo[QW]),
    .side_i        (ch_side[QW]),
    .aw            (aw_r),
    .ah            (ah_r),
    .mode          (mode_r),
    .vld_o         (stg_vld[NS-1]),
    .valid_res     (out_valid_res),
    .landscape     (out_landscape),
    .scale_factor  (out_scale_factor),
    .dest_width    (out_dest_width),
    .dest_height   (out_dest_height),
    .dest_x        (out_dest_x),
    .dest_y        (out_dest_y),
    .will_crop     (out_will_crop),
    .crop_fraction (out_crop_fraction)
  );

  assign out_valid = stg_vld[NS-1];

endmodule

>>> hdl/fpp_checker.sv
// ----------------------------------------------------------------------------
// fpp_checker
// Port-level checks on the result channel of the page placement block.
// ----------------------------------------------------------------------------
module fpp_checker
  import fpp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic                    out_valid_res,
  input  logic                    out_landscape,
  input  logic [RESW-1:0]         out_scale_factor,
  input  logic [RESW-1:0]         out_dest_width,
  input  logic [RESW-1:0]         out_dest_height,
  input  logic                    out_will_crop,
  input  logic [CROPW-1:0]        out_crop_fraction
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_dest_width) &&
      $stable(out_scale_factor))
    else $error("result item changed while stalled");

  a_min_dim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |-> out_dest_width != '0 && out_dest_height != '0)
    else $error("valid result with zero dimension");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> !out_landscape && out_scale_factor == '0 &&
      out_dest_width == '0 && !out_will_crop && out_crop_fraction == '0)
    else $error("invalid result is not all zero");

  a_crop_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_will_crop |-> out_crop_fraction == '0)
    else $error("crop fraction without crop flag");

endmodule

bind fit_page_placement fpp_checker u_fpp_checker (.*);
